// ----- hdl/nmsc_pkg.sv -----
package nmsc_pkg;

    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int PixW      = 24;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 20;

    localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFlat   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegLow    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegNormal = 3'd4;
    localparam logic [CfgIdxW-1:0] RegHigh   = 3'd5;

    localparam logic [2:0] CostFlat   = 3'd0;
    localparam logic [2:0] CostLow    = 3'd1;
    localparam logic [2:0] CostNormal = 3'd2;
    localparam logic [2:0] CostHigh   = 3'd3;
    localparam logic [2:0] CostWall   = 3'd4;

    // per-item facts the datapath reports to the controller
    typedef struct packed {
        logic need_inner;   // result for (c-1, r-1), or (c, 0) in row 0
        logic need_edge;    // wall at (W-1, r-1)
        logic need_bottom;  // wall at (c, r)
        logic inner_wall;   // inner result is a border pixel
        logic frame_end;
    } nmsc_status_t;

    // controller commands to the datapath
    typedef struct packed {
        logic       accept;      // take the input item, start reads
        logic       window;      // shift window with read data
        logic       mult;        // register squares
        logic       prod;        // register threshold products
        logic       load_out;    // load output register
        logic [1:0] out_sel;     // 0 inner, 1 edge, 2 bottom
        logic       out_last;
    } nmsc_cmd_t;

    localparam logic [1:0] SelInner  = 2'd0;
    localparam logic [1:0] SelEdge   = 2'd1;
    localparam logic [1:0] SelBottom = 2'd2;

endpackage

// ----- hdl/nmsc_ram.sv -----
module nmsc_ram #(
    parameter int Width = 24,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/nmsc_datapath.sv -----
module nmsc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nmsc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [nmsc_pkg::CfgDataW-1:0] cfg_data,
    input  logic [7:0]                    s_red_byte,
    input  logic [7:0]                    s_green_byte,
    input  logic [7:0]                    s_blue_byte,
    input  nmsc_pkg::nmsc_cmd_t           cmd,
    output nmsc_pkg::nmsc_status_t        status,
    output logic [2:0]                    m_cost_class,
    output logic [11:0]                   m_column,
    output logic [11:0]                   m_row,
    output logic                          m_last_of_run,
    output logic                          m_frame_done
);

    localparam int ColW = nmsc_pkg::ColW;
    localparam int RowW = nmsc_pkg::RowW;
    localparam int PixW = nmsc_pkg::PixW;

    // configuration registers
    logic [12:0] width_reg, height_reg;
    logic [19:0] lim_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1024;
            height_reg <= 13'd1024;
            lim_reg[0] <= 20'd4096;
            lim_reg[1] <= 20'd5898;
            lim_reg[2] <= 20'd10486;
            lim_reg[3] <= 20'd16384;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nmsc_pkg::RegWidth:  width_reg  <= cfg_data[12:0];
                nmsc_pkg::RegHeight: height_reg <= cfg_data[12:0];
                nmsc_pkg::RegFlat:   lim_reg[0] <= cfg_data;
                nmsc_pkg::RegLow:    lim_reg[1] <= cfg_data;
                nmsc_pkg::RegNormal: lim_reg[2] <= cfg_data;
                nmsc_pkg::RegHigh:   lim_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective last column/row, saturated to the supported range
    logic [ColW-1:0] last_c;
    logic [RowW-1:0] last_r;
    always_comb begin
        if (width_reg < 13'd3)                last_c = ColW'(2);
        else if (width_reg > 13'(nmsc_pkg::MaxWidth)) last_c = ColW'(nmsc_pkg::MaxWidth - 1);
        else                                  last_c = ColW'(width_reg - 13'd1);
        if (height_reg < 13'd3)               last_r = RowW'(2);
        else if (height_reg > 13'(nmsc_pkg::MaxHeight)) last_r = RowW'(nmsc_pkg::MaxHeight - 1);
        else                                  last_r = RowW'(height_reg - 13'd1);
    end

    // position counters
    logic [ColW-1:0] col_reg, col_next, c_eff, c_reg;
    logic [RowW-1:0] row_reg, row_next, r_eff, r_reg;
    assign c_eff = (col_reg > last_c) ? last_c : col_reg;
    assign r_eff = (row_reg > last_r) ? last_r : row_reg;

    always_comb begin
        if (c_eff >= last_c) begin
            col_next = '0;
            row_next = (r_eff >= last_r) ? '0 : r_eff + RowW'(1);
        end else begin
            col_next = c_eff + ColW'(1);
            row_next = r_eff;
        end
    end

    logic [PixW-1:0] pix_reg;
    logic [ColW-1:0] last_c_reg;
    logic [RowW-1:0] last_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            c_reg      <= c_eff;
            r_reg      <= r_eff;
            last_c_reg <= last_c;
            last_r_reg <= last_r;
            pix_reg    <= {s_blue_byte, s_green_byte, s_red_byte};
        end
    end

    // line stores: read at accept, written when the window shifts
    logic [PixW-1:0] up_rd, mid_rd;
    nmsc_ram #(.Width(PixW), .Depth(nmsc_pkg::MaxWidth)) u_upper (
        .aclk(aclk), .we(cmd.window), .waddr(c_reg), .wdata(mid_rd),
        .raddr(c_eff), .rdata(up_rd)
    );
    nmsc_ram #(.Width(PixW), .Depth(nmsc_pkg::MaxWidth)) u_middle (
        .aclk(aclk), .we(cmd.window), .waddr(c_reg), .wdata(pix_reg),
        .raddr(c_eff), .rdata(mid_rd)
    );

    // 3x3 window, [row][col], col 2 newest
    logic [PixW-1:0] win_reg [3][3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cmd.window) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= pix_reg;
        end
    end

    // channel sums, D = 2*S - 2295 (range +-2295)
    logic signed [12:0] d [3];
    always_comb begin
        logic [11:0] s;
        for (int k = 0; k < 3; k++) begin
            s = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    s = s + 12'(win_reg[i][j][8*k +: 8]);
                end
            end
            d[k] = $signed({s, 1'b0}) - 13'sd2295;
        end
    end

    // squares, kept as 24-bit unsigned values, at most 2295^2
    logic [23:0] x2_reg, y2_reg, z2_reg;
    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            x2_reg <= 24'(26'(d[0]) * 26'(d[0]));
            y2_reg <= 24'(26'(d[1]) * 26'(d[1]));
            z2_reg <= 24'(26'(d[2]) * 26'(d[2]));
        end
    end

    // products and class
    logic [40:0] lhs_reg;
    logic [43:0] rhs_reg [4];
    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            lhs_reg <= {25'(x2_reg) + 25'(y2_reg), 16'd0};
            for (int k = 0; k < 4; k++) begin
                rhs_reg[k] <= 44'(lim_reg[k]) * 44'(z2_reg);
            end
        end
    end

    logic [2:0] cls;
    always_comb begin
        priority if (44'(lhs_reg) < rhs_reg[0]) cls = nmsc_pkg::CostFlat;
        else if (44'(lhs_reg) < rhs_reg[1])     cls = nmsc_pkg::CostLow;
        else if (44'(lhs_reg) < rhs_reg[2])     cls = nmsc_pkg::CostNormal;
        else if (44'(lhs_reg) < rhs_reg[3])     cls = nmsc_pkg::CostHigh;
        else                                    cls = nmsc_pkg::CostWall;
    end

    // status for the controller
    assign status.need_inner  = (r_reg == '0) || (c_reg != '0);
    assign status.need_edge   = (r_reg != '0) && (c_reg == last_c_reg);
    assign status.need_bottom = (r_reg != '0) && (r_reg == last_r_reg);
    assign status.inner_wall  = (r_reg < RowW'(2)) || (c_reg < ColW'(2));
    assign status.frame_end   = (c_reg == last_c_reg) && (r_reg == last_r_reg);

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_last_of_run <= cmd.out_last;
            m_frame_done  <= cmd.out_last && status.frame_end;
            unique case (cmd.out_sel)
                nmsc_pkg::SelInner: begin
                    if (r_reg == '0) begin
                        m_cost_class <= nmsc_pkg::CostWall;
                        m_column     <= 12'(c_reg);
                        m_row        <= '0;
                    end else begin
                        m_cost_class <= status.inner_wall ? nmsc_pkg::CostWall : cls;
                        m_column     <= 12'(c_reg - ColW'(1));
                        m_row        <= 12'(r_reg - RowW'(1));
                    end
                end
                nmsc_pkg::SelEdge: begin
                    m_cost_class <= nmsc_pkg::CostWall;
                    m_column     <= 12'(last_c_reg);
                    m_row        <= 12'(r_reg - RowW'(1));
                end
                default: begin
                    m_cost_class <= nmsc_pkg::CostWall;
                    m_column     <= 12'(c_reg);
                    m_row        <= 12'(r_reg);
                end
            endcase
        end
    end

endmodule

// ----- hdl/nmsc_ctrl.sv -----
module nmsc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  nmsc_pkg::nmsc_status_t status,
    output nmsc_pkg::nmsc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_MULT  = 6'b000100,
        S_PROD  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       mvalid_reg, mvalid_next;

    // choose next result after sel, given what is required
    function automatic logic [1:0] pick(input logic [2:0] need, input logic [1:0] from);
        logic [1:0] r;
        r = nmsc_pkg::SelBottom;
        for (int k = 2; k >= 0; k--) begin
            if (need[k] && 2'(k) >= from) r = 2'(k);
        end
        return r;
    endfunction

    logic [2:0] need;
    logic       has_more;
    assign need = {status.need_bottom, status.need_edge, status.need_inner};
    always_comb begin
        has_more = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (need[k] && 2'(k) > sel_reg) has_more = 1'b1;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) state_next = S_READ;
            end
            S_READ: begin
                cmd.window = 1'b1;
                state_next = S_MULT;
            end
            S_MULT: begin
                cmd.mult   = 1'b1;
                state_next = S_PROD;
            end
            S_PROD: begin
                cmd.prod = 1'b1;
                // an item that only fills the window causes no result
                if (need == '0) begin
                    state_next = S_IDLE;
                end else begin
                    sel_next   = pick(need, 2'd0);
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = sel_reg;
                    cmd.out_last = !has_more;
                    mvalid_next  = 1'b1;
                    if (has_more) begin
                        sel_next = pick(need, sel_reg + 2'd1);
                    end else begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (!mvalid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sel_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ----- hdl/normal_map_slope_cost_top.sv -----
// Normal-map slope classifier. Pixels enter in raster order (red, green,
// blue bytes); each causes zero to three results (cost 0..4, column, row),
// border pixels are wall. An item passes through the line-store read, the
// square and threshold-multiply registers and the result sequencer; further
// results follow one per cycle while the receiver takes them, and the next
// item is taken only after the last result has left the output register, so
// one item is handled at a time. The line stores need no clearing after
// reset.
module normal_map_slope_cost_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nmsc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [nmsc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_red_byte,
    input  logic [7:0]                    s_green_byte,
    input  logic [7:0]                    s_blue_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_cost_class,
    output logic [11:0]                   m_column,
    output logic [11:0]                   m_row,
    output logic                          m_last_of_run,
    output logic                          m_frame_done
);

    nmsc_pkg::nmsc_cmd_t    cmd;
    nmsc_pkg::nmsc_status_t status;

    nmsc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .status(status), .cmd(cmd)
    );

    nmsc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_red_byte(s_red_byte), .s_green_byte(s_green_byte),
        .s_blue_byte(s_blue_byte), .cmd(cmd), .status(status),
        .m_cost_class(m_cost_class), .m_column(m_column), .m_row(m_row),
        .m_last_of_run(m_last_of_run), .m_frame_done(m_frame_done)
    );

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import nmsc_pkg::*;

    // one classified pixel as it leaves the block
    typedef struct packed {
        logic [2:0]  cost;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
        logic        done;
    } cost_result_t;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                cfg_we = 0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                s_valid = 0;
    logic                s_ready;
    logic [7:0]          s_red_byte = '0;
    logic [7:0]          s_green_byte = '0;
    logic [7:0]          s_blue_byte = '0;
    logic                m_valid;
    logic                m_ready = 0;
    logic [2:0]          m_cost_class;
    logic [11:0]         m_column;
    logic [11:0]         m_row;
    logic                m_last_of_run;
    logic                m_frame_done;

    normal_map_slope_cost_top dut (.*);

    // predictor state
    logic [12:0]    width_reg, height_reg;
    logic [19:0]    limit_sq [4];
    logic [PixW-1:0] line_above2 [MaxWidth];
    logic [PixW-1:0] line_above1 [MaxWidth];
    logic [PixW-1:0] win [3][3];
    int             col_pos, row_pos;

    cost_result_t   pending_costs [$];
    int             mismatches = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    logic           hold_on = 0;
    int             random_items = 0;

    initial forever #5 aclk = ~aclk;

    function automatic int clamp_dim(int v);
        if (v < 3) return 3;
        if (v > MaxWidth) return MaxWidth;
        return v;
    endfunction

    // box-sum difference for one channel: 2*S - 2295
    function automatic longint chan_diff(int shift);
        int s;
        s = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                s += (win[i][j] >> shift) & 8'hFF;
        return 2 * longint'(s) - 2295;
    endfunction

    function automatic logic [2:0] slope_cost();
        longint dx, dy, dz, lhs, z2;
        dx = chan_diff(0);
        dy = chan_diff(8);
        dz = chan_diff(16);
        lhs = (dx * dx + dy * dy) * 65536;
        z2 = dz * dz;
        if (lhs < longint'(limit_sq[0]) * z2) return CostFlat;
        if (lhs < longint'(limit_sq[1]) * z2) return CostLow;
        if (lhs < longint'(limit_sq[2]) * z2) return CostNormal;
        if (lhs < longint'(limit_sq[3]) * z2) return CostHigh;
        return CostWall;
    endfunction

    function automatic void push_cost(logic [2:0] cost, int c, int r);
        cost_result_t e;
        e.cost = cost;
        e.col = c[11:0];
        e.row = r[11:0];
        e.last = 0;
        e.done = 0;
        pending_costs = {pending_costs, e};
    endfunction

    // advance the predictor by one accepted pixel
    function automatic void predict_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
        int w, h, c, r, n;
        logic [PixW-1:0] pix;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        r = (row_pos > h - 1) ? h - 1 : row_pos;
        pix = {bl, gr, rd};
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_above2[c];
        win[1][2] = line_above1[c];
        win[2][2] = pix;
        line_above2[c] = line_above1[c];
        line_above1[c] = pix;
        n = pending_costs.size();
        if (r == 0) begin
            push_cost(CostWall, c, 0);
        end else begin
            if (c >= 1)
                push_cost((c >= 2 && r >= 2) ? slope_cost() : CostWall, c - 1, r - 1);
            if (c == w - 1) push_cost(CostWall, w - 1, r - 1);
            if (r == h - 1) push_cost(CostWall, c, r);
        end
        if (pending_costs.size() > n) begin
            pending_costs[pending_costs.size() - 1].last = 1;
            pending_costs[pending_costs.size() - 1].done = (c == w - 1 && r == h - 1);
        end
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // register write, block must be idle
    task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value[CfgDataW-1:0];
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            RegWidth:  width_reg = value[12:0];
            RegHeight: height_reg = value[12:0];
            RegFlat:   limit_sq[0] = value[19:0];
            RegLow:    limit_sq[1] = value[19:0];
            RegNormal: limit_sq[2] = value[19:0];
            RegHigh:   limit_sq[3] = value[19:0];
            default: ;
        endcase
    endtask

    task automatic write_limits(int unsigned f, int unsigned l, int unsigned n, int unsigned hi);
        write_reg(RegFlat, f);
        write_reg(RegLow, l);
        write_reg(RegNormal, n);
        write_reg(RegHigh, hi);
    endtask

    task automatic send_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1;
        s_red_byte <= rd;
        s_green_byte <= gr;
        s_blue_byte <= bl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(rd, gr, bl);
    endtask

    // mostly gentle tilts so every cost class shows up, some full noise
    task automatic send_tilted(int tilt);
        if ($urandom_range(0, 9) == 0)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_pixel(8'(127 + $urandom_range(0, tilt) - tilt / 2),
                       8'(127 + $urandom_range(0, tilt) - tilt / 2),
                       8'($urandom_range(190, 255)));
    endtask

    task automatic finish_frame(int tilt);
        do begin
            send_tilted(tilt);
            random_items++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // drain results, then cover an item that produced nothing yet
    task automatic wait_drained();
        @(posedge aclk);
        s_valid <= 0;
        while (pending_costs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // result side: check each accepted result
    always @(posedge aclk) begin
        cost_result_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = {m_cost_class, m_column, m_row, m_last_of_run, m_frame_done};
            if (pending_costs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result cost=%0d col=%0d row=%0d",
                             got.cost, got.col, got.row);
            end else begin
                exp_r = pending_costs.pop_front();
                if (got.cost !== exp_r.cost || got.col !== exp_r.col ||
                    got.row !== exp_r.row || got.last !== exp_r.last ||
                    got.done !== exp_r.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp cost=%0d col=%0d row=%0d last=%0b done=%0b",
                                 exp_r.cost, exp_r.col, exp_r.row, exp_r.last, exp_r.done,
                                 " got cost=%0d col=%0d row=%0d last=%0b done=%0b",
                                 got.cost, got.col, got.row, got.last, got.done);
                end
            end
        end
    end

    // receiver: random stalls, or held off entirely during a long hold
    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= !hold_on && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // small frames with extreme bytes, the first with dimensions below range
    task automatic test_directed();
        write_reg(RegWidth, 1);
        write_reg(RegHeight, 2);
        write_limits(4096, 5898, 10486, 16384);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h7F, 8'h80, 8'hFF);
        send_pixel(8'h80, 8'h7F, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h55, 8'hAA, 8'h01);
        wait_drained();
        // 4x3 frame with flat and tilted interiors
        write_reg(RegWidth, 4);
        write_reg(RegHeight, 3);
        for (int i = 0; i < 12; i++)
            send_pixel(8'(127 + i * 4), 8'(128 - i * 3), 8'hFF);
        wait_drained();
    endtask

    // limit extremes and unordered limits
    task automatic test_limit_extremes();
        write_reg(RegWidth, 3);
        write_reg(RegHeight, 3);
        write_limits(0, 0, 0, 0);
        finish_frame(40);
        wait_drained();
        write_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        finish_frame(255);
        wait_drained();
        write_limits(16384, 4096, 20'hFFFFF, 0);
        finish_frame(60);
        wait_drained();
    endtask

    task automatic test_random_frames(int quota);
        int goal;
        goal = random_items + quota;
        while (random_items < goal) begin
            write_reg(RegWidth, $urandom_range(3, 5));
            write_reg(RegHeight, $urandom_range(3, 4));
            write_limits($urandom_range(0, 8000), $urandom_range(3000, 12000),
                         $urandom_range(6000, 30000), $urandom_range(10000, 60000));
            finish_frame($urandom_range(0, 80));
            wait_drained();
        end
    endtask

    // shrink width, then height, in the middle of a frame
    task automatic test_resize_mid_frame();
        write_reg(RegWidth, 6);
        write_reg(RegHeight, 5);
        repeat (10) send_tilted(50);
        wait_drained();
        write_reg(RegWidth, 3);
        finish_frame(50);
        wait_drained();
        write_reg(RegHeight, 8);
        repeat (16) send_tilted(50);
        wait_drained();
        write_reg(RegHeight, 4);
        finish_frame(50);
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering items
    task automatic test_backpressure();
        write_reg(RegWidth, 4);
        write_reg(RegHeight, 4);
        fork
            begin
                hold_on <= 1;
                repeat (300) @(posedge aclk);
                hold_on <= 0;
            end
        join_none
        finish_frame(60);
        wait_drained();
    endtask

    // widest and tallest settings, including values above range, shrunk part way
    task automatic test_max_dims();
        write_limits(4096, 5898, 10486, 16384);
        write_reg(RegWidth, 8191);
        write_reg(RegHeight, 3);
        repeat (8) send_tilted(40);
        wait_drained();
        write_reg(RegWidth, 4);
        finish_frame(40);
        wait_drained();
        write_reg(RegWidth, 3);
        write_reg(RegHeight, 8191);
        repeat (9) send_tilted(40);
        wait_drained();
        write_reg(RegHeight, 4);
        finish_frame(40);
        wait_drained();
    endtask

    initial begin
        width_reg = 1024;
        height_reg = 1024;
        limit_sq[0] = 4096;
        limit_sq[1] = 5898;
        limit_sq[2] = 10486;
        limit_sq[3] = 16384;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 54;
        test_directed();
        test_limit_extremes();
        test_random_frames(8);
        send_idle_pct = 54;
        recv_idle_pct = 13;
        test_resize_mid_frame();
        test_backpressure();
        test_random_frames(8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(8);
        test_max_dims();

        if (pending_costs.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("normal_map_slope_cost_top regression: pass");
        else
            $display("normal_map_slope_cost_top regression: fail");
        $finish;
    end

    initial begin
        #1000000;
        $display("normal_map_slope_cost_top regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/nmsc_pkg.sv
hdl/nmsc_ram.sv
hdl/nmsc_datapath.sv
hdl/nmsc_ctrl.sv
hdl/normal_map_slope_cost_top.sv
bench/testbench.sv
